>>> hdl/rtcbcd_pkg.sv
`timescale 1ns / 1ps
// rtcbcd_pkg: constants and helper functions for the rtc bcd to epoch seconds core
// no dependencies; imported by rtc_bcd_to_epoch_seconds_core and its testbench

package rtcbcd_pkg;

    localparam int EPOCH_YEAR       = 1970;
    localparam int CENTURY_19       = 1900;
    localparam int CENTURY_20       = 2000;
    localparam int YY_PIVOT         = 70;
    localparam int YEAR_SPAN_DEF    = 100;
    localparam int SEC_PER_MIN      = 60;
    localparam int SEC_PER_HOUR     = 3600;
    localparam int SEC_PER_DAY      = 86400;
    localparam int DAYS_PER_YEAR    = 365;
    localparam int MONTHS_PER_YEAR  = 12;

    localparam int BYTE_W   = 8;
    localparam int YEAR_W   = 12;   // full year 1971..2070
    localparam int YOFF_W   = 7;    // year offset from 1970, span limited to 127
    localparam int MONTH_W  = 4;
    localparam int DBM_W    = 9;    // days before month, up to 334
    localparam int DAYS_W   = 16;   // day count plus day of month, below 65536
    localparam int TOD_W    = 20;   // unchecked time of day, up to 604065
    localparam int SECS_W   = 32;

    // month codes
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;

    // stage two payload: everything but the day to seconds scaling
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
        logic              month_fixed;
        logic              year_fixed;
    } mid_t;

    // low nibble plus ten times high nibble, nibbles above nine pass through
    function automatic logic [BYTE_W-1:0] bcd_value(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] hi;
        hi = {4'd0, b[7:4]};
        return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    // days before the first of the month in a common year
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/rtc_bcd_to_epoch_seconds_core.sv
`timescale 1ns / 1ps
// rtc_bcd_to_epoch_seconds_core: rtc bcd date and time to seconds since 1970
// depends on rtcbcd_pkg (constants, bcd decode, month table, stage struct)

// Converts one request of six rtc bytes (second, minute, hour, day of month,
// month, two-digit year, all bcd) into seconds since 1970-01-01 00:00:00.
// A request is taken every cycle while item_stall is low; it passes the input
// register, the day count register and the result register in that order,
// with the arithmetic split between the day count and result registers.
// Two-digit years above 70 mean 19xx, the rest 20xx. A month outside 1..12
// is replaced by january and month_fixed is raised; a year past
// 1970+YEAR_SPAN is replaced by 1970 and year_fixed is raised. Second,
// minute, hour and day of month are used as decoded, unchecked, and a day of
// month of zero wraps the result modulo 2^32 when it falls before the epoch.
// YEAR_SPAN must stay in 1..127.

module rtc_bcd_to_epoch_seconds_core
    import rtcbcd_pkg::*;
#(
    parameter int YEAR_SPAN = YEAR_SPAN_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [BYTE_W-1:0] sec_bcd,
    input  logic [BYTE_W-1:0] min_bcd,
    input  logic [BYTE_W-1:0] hour_bcd,
    input  logic [BYTE_W-1:0] mday_bcd,
    input  logic [BYTE_W-1:0] month_bcd,
    input  logic [BYTE_W-1:0] year_bcd,
    // result channel
    output logic              result_valid,
    input  logic              result_stall,
    output logic [SECS_W-1:0] epoch_seconds,
    output logic              month_fixed,
    output logic              year_fixed
);

    // pipeline control: each stage loads when empty or when it drains
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_load, s2_load, out_load;

    // stage one: raw request bytes
    logic [BYTE_W-1:0] sec_reg, min_reg, hour_reg, mday_reg, month_reg, year_reg;

    // stage two: day count and time of day
    mid_t mid_reg, mid_next;

    // result register
    logic [SECS_W-1:0] secs_reg, secs_next;
    logic              month_fixed_reg, year_fixed_reg;

    // stage one decode
    logic [BYTE_W-1:0]  sec_d, min_d, hour_d, mday_d, mon_d, yy_d;
    logic               mon_bad, year_bad, leap_yr;
    logic [MONTH_W-1:0] mon_use;
    logic [YEAR_W-1:0]  full_year, year_off_raw;
    logic [YOFF_W-1:0]  year_off;
    logic [BYTE_W-1:0]  year_off_p1;
    logic [DBM_W-1:0]   dbm;

    assign out_load = !out_valid_reg || !result_stall;
    assign s2_load  = !s2_valid_reg || out_load;
    assign s1_load  = !s1_valid_reg || s2_load;

    assign item_stall    = !s1_load;
    assign result_valid  = out_valid_reg;
    assign epoch_seconds = secs_reg;
    assign month_fixed   = month_fixed_reg;
    assign year_fixed    = year_fixed_reg;

    always_comb
    begin
        s1_valid_next  = s1_load  ? item_valid   : s1_valid_reg;
        s2_valid_next  = s2_load  ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_load ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s1_load && item_valid)
        begin
            sec_reg   <= sec_bcd;
            min_reg   <= min_bcd;
            hour_reg  <= hour_bcd;
            mday_reg  <= mday_bcd;
            month_reg <= month_bcd;
            year_reg  <= year_bcd;
        end
    end

    // decode, clamp month and year, count days up to the day of month
    always_comb
    begin
        sec_d  = bcd_value(sec_reg);
        min_d  = bcd_value(min_reg);
        hour_d = bcd_value(hour_reg);
        mday_d = bcd_value(mday_reg);
        mon_d  = bcd_value(month_reg);
        yy_d   = bcd_value(year_reg);

        mon_bad = (mon_d == '0) || (mon_d > BYTE_W'(MONTHS_PER_YEAR));
        mon_use = mon_bad ? MON_JAN : mon_d[MONTH_W-1:0];

        // two-digit year window
        full_year = YEAR_W'(yy_d) + ((yy_d > BYTE_W'(YY_PIVOT)) ?
                    YEAR_W'(CENTURY_19) : YEAR_W'(CENTURY_20));
        // full year is never below 1971, so the offset cannot underflow
        year_off_raw = full_year - YEAR_W'(EPOCH_YEAR);
        year_bad     = year_off_raw > YEAR_W'(YEAR_SPAN);
        year_off     = year_bad ? '0 : year_off_raw[YOFF_W-1:0];

        // within 1970..2097 every year with offset 2 mod 4 is leap (2000 included),
        // so leap years before this one number (offset + 1) / 4
        leap_yr     = (year_off[1:0] == 2'b10);
        year_off_p1 = BYTE_W'(year_off) + BYTE_W'(1);
        dbm         = days_before_month(mon_use);

        // day of month is kept whole here; the minus one day is applied at the end
        mid_next.days = DAYS_W'(year_off) * DAYS_W'(DAYS_PER_YEAR)
                      + DAYS_W'(year_off_p1[BYTE_W-1:2])
                      + DAYS_W'(dbm)
                      + DAYS_W'((mon_use > MON_FEB) && leap_yr)
                      + DAYS_W'(mday_d);
        mid_next.tod  = TOD_W'(hour_d) * TOD_W'(SEC_PER_HOUR)
                      + TOD_W'(min_d) * TOD_W'(SEC_PER_MIN)
                      + TOD_W'(sec_d);
        mid_next.month_fixed = mon_bad;
        mid_next.year_fixed  = year_bad;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            mid_reg <= mid_next;
        end
    end

    // scale days to seconds, modulo 2^32
    always_comb
    begin
        secs_next = SECS_W'(32'(mid_reg.days) * 32'(SEC_PER_DAY))
                  + SECS_W'(mid_reg.tod)
                  - SECS_W'(SEC_PER_DAY);
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s2_valid_reg)
        begin
            secs_reg        <= secs_next;
            month_fixed_reg <= mid_reg.month_fixed;
            year_fixed_reg  <= mid_reg.year_fixed;
        end
    end

endmodule

>>> verif/tb_rtc_bcd_to_epoch_seconds_core.sv
`timescale 1ns / 1ps
// tb_rtc_bcd_to_epoch_seconds_core: self-checking bench for the rtc bcd to epoch seconds core
// depends on rtcbcd_pkg and rtc_bcd_to_epoch_seconds_core; standalone, no files read

module tb_rtc_bcd_to_epoch_seconds_core;
    import rtcbcd_pkg::*;

    localparam int YEAR_SPAN     = YEAR_SPAN_DEF;
    localparam int RANDOM_ITEMS  = 650;
    // idle and stall chance in percent, and a stretch of cycles with neither
    localparam int GAP_PCT       = 29;
    localparam int CALM_FIRST    = 200;
    localparam int CALM_LAST     = 450;
    // extra cycles run after the last expected result has been checked
    localparam int DRAIN_CYCLES  = 8;
    localparam int RUN_LIMIT_NS  = 400000;

    // one request: six rtc bytes
    typedef struct packed {
        logic [BYTE_W-1:0] sec;
        logic [BYTE_W-1:0] min;
        logic [BYTE_W-1:0] hour;
        logic [BYTE_W-1:0] mday;
        logic [BYTE_W-1:0] month;
        logic [BYTE_W-1:0] year;
    } clock_bytes_t;

    // one result: seconds since epoch and the two repair flags
    typedef struct packed {
        logic [SECS_W-1:0] secs;
        logic              month_fixed;
        logic              year_fixed;
    } epoch_stamp_t;

    // days before the first of each month, common year
    localparam int unsigned DAYS_AHEAD [1:12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [BYTE_W-1:0] sec_bcd = '0;
    logic [BYTE_W-1:0] min_bcd = '0;
    logic [BYTE_W-1:0] hour_bcd = '0;
    logic [BYTE_W-1:0] mday_bcd = '0;
    logic [BYTE_W-1:0] month_bcd = '0;
    logic [BYTE_W-1:0] year_bcd = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [SECS_W-1:0] epoch_seconds;
    logic              month_fixed;
    logic              year_fixed;

    clock_bytes_t pending_requests [$];
    epoch_stamp_t expected_stamps [$];
    logic         req_taken = 1'b0;
    int           requests_total = 0;
    int           requests_taken = 0;
    int           cycle_count = 0;
    int           mismatch_count = 0;
    logic         calm;

    rtc_bcd_to_epoch_seconds_core #(
        .YEAR_SPAN(YEAR_SPAN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .sec_bcd(sec_bcd),
        .min_bcd(min_bcd),
        .hour_bcd(hour_bcd),
        .mday_bcd(mday_bcd),
        .month_bcd(month_bcd),
        .year_bcd(year_bcd),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .epoch_seconds(epoch_seconds),
        .month_fixed(month_fixed),
        .year_fixed(year_fixed)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // no gaps on either side inside this window
    assign calm = (cycle_count >= CALM_FIRST) && (cycle_count <= CALM_LAST);

    // leap years in 1..n
    function automatic int unsigned leaps_through(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // seconds since 1970 for one request, wrapping modulo 2^32
    function automatic epoch_stamp_t epoch_of_clock(input clock_bytes_t c);
        epoch_stamp_t r;
        int unsigned  sec_v;
        int unsigned  min_v;
        int unsigned  hour_v;
        int unsigned  mday_v;
        int unsigned  mon_v;
        int unsigned  yy_v;
        int unsigned  year_v;
        int unsigned  days;
        sec_v  = c.sec[3:0] + 10 * c.sec[7:4];
        min_v  = c.min[3:0] + 10 * c.min[7:4];
        hour_v = c.hour[3:0] + 10 * c.hour[7:4];
        mday_v = c.mday[3:0] + 10 * c.mday[7:4];
        mon_v  = c.month[3:0] + 10 * c.month[7:4];
        yy_v   = c.year[3:0] + 10 * c.year[7:4];
        r.month_fixed = 1'b0;
        r.year_fixed  = 1'b0;
        if (mon_v < MON_JAN || mon_v > MONTHS_PER_YEAR)
        begin
            mon_v = MON_JAN;
            r.month_fixed = 1'b1;
        end
        year_v = yy_v + ((yy_v > YY_PIVOT) ? CENTURY_19 : CENTURY_20);
        if (year_v < EPOCH_YEAR || year_v > EPOCH_YEAR + YEAR_SPAN)
        begin
            year_v = EPOCH_YEAR;
            r.year_fixed = 1'b1;
        end
        days = (year_v - EPOCH_YEAR) * DAYS_PER_YEAR
             + leaps_through(year_v - 1) - leaps_through(EPOCH_YEAR - 1);
        days += DAYS_AHEAD[mon_v];
        if (mon_v > MON_FEB &&
            (((year_v % 4 == 0) && (year_v % 100 != 0)) || (year_v % 400 == 0)))
            days += 1;
        days = days + mday_v - 1;
        r.secs = days * SEC_PER_DAY + hour_v * SEC_PER_HOUR + min_v * SEC_PER_MIN + sec_v;
        return r;
    endfunction

    // two-digit bcd byte from a value 0..99
    function automatic logic [BYTE_W-1:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    task automatic queue_request(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] mi,
                                 input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] d,
                                 input logic [BYTE_W-1:0] mo, input logic [BYTE_W-1:0] y);
        clock_bytes_t c;
        c = '{sec: s, min: mi, hour: h, mday: d, month: mo, year: y};
        pending_requests.push_back(c);
        requests_total++;
    endtask

    // driver: new request or idle at the falling edge, hold while stalled
    always @(negedge clk)
    begin : drive_requests
        clock_bytes_t nxt;
        if (rst_n && (!item_valid || req_taken))
        begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= GAP_PCT))
            begin
                nxt = pending_requests.pop_front();
                item_valid <= 1'b1;
                sec_bcd    <= nxt.sec;
                min_bcd    <= nxt.min;
                hour_bcd   <= nxt.hour;
                mday_bcd   <= nxt.mday;
                month_bcd  <= nxt.month;
                year_bcd   <= nxt.year;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        // receiver back-pressure, off in the calm window
        result_stall <= rst_n && !calm && ($urandom_range(99) < GAP_PCT);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : watch_channels
        epoch_stamp_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            req_taken   <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                expected_stamps.push_back(epoch_of_clock({sec_bcd, min_bcd, hour_bcd,
                                                          mday_bcd, month_bcd, year_bcd}));
                requests_taken <= requests_taken + 1;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_stamps.size() == 0)
                begin
                    $error("unexpected result epoch_seconds=%0h", epoch_seconds);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_stamps.pop_front();
                    if (epoch_seconds !== want.secs)
                    begin
                        $error("epoch_seconds expected %0h actual %0h", want.secs, epoch_seconds);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (month_fixed !== want.month_fixed)
                    begin
                        $error("month_fixed expected %0b actual %0b", want.month_fixed, month_fixed);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (year_fixed !== want.year_fixed)
                    begin
                        $error("year_fixed expected %0b actual %0b", want.year_fixed, year_fixed);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned dmax;
        // directed: epoch edges, every month, leap rules, repairs, raw nibbles
        queue_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h71);   // 1971-01-01 start
        queue_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // all zero, month repaired
        queue_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // all ones
        queue_request(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);   // last second of 1999
        queue_request(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00);   // 2000 leap by 400 rule
        queue_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00);
        queue_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h99);   // common year march
        queue_request(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h70);   // top of span, 2070
        queue_request(8'h07, 8'h14, 8'h03, 8'h15, 8'h13, 8'h24);   // month 13 repaired
        queue_request(8'h00, 8'h00, 8'h00, 8'h01, 8'hAF, 8'h24);   // month nibble above nine
        queue_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h71);   // day zero in 1971
        queue_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hA0);   // yy 100 gives 2000
        queue_request(8'hF9, 8'h9F, 8'hAA, 8'hFA, 8'h05, 8'hF5);   // yy 155 gives 2055
        for (int m = 1; m <= 12; m++)
            queue_request(8'h30, 8'h45, 8'h12, 8'h28, to_bcd(m), 8'h24);

        // random: mostly sane calendar bytes, some raw noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                dmax = $urandom_range(1) ? 28 : 31;
                queue_request(to_bcd($urandom_range(59)), to_bcd($urandom_range(59)),
                              to_bcd($urandom_range(23)), to_bcd($urandom_range(dmax, 1)),
                              to_bcd($urandom_range(12, 1)), to_bcd($urandom_range(99)));
            end
            else
            begin
                queue_request(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_taken < requests_total || expected_stamps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && expected_stamps.size() == 0)
            $display("tb_rtc_bcd_to_epoch_seconds_core OK");
        else
            $display("tb_rtc_bcd_to_epoch_seconds_core NOT OK");
        $finish;
    end

    // watchdog against a hung handshake
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_rtc_bcd_to_epoch_seconds_core NOT OK");
        $finish;
    end

endmodule
